/* rtl/core/tidl_pkg.sv */
// Shared constants and types of the timestamped interpolating delay unit.
package tidl_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;

  localparam int DVD_W = 50;
  localparam int DVS_W = 34;
  localparam int DCNT_W = 6;

  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_INIT  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_YOUNG = 2'd1;
  localparam logic [1:0] ST_EARLY = 2'd2;
  localparam logic [1:0] ST_DROP  = 2'd3;

  typedef logic signed [31:0] q16_t;

endpackage

/* rtl/core/tidl_if.sv */
// Request and result channel interfaces.
interface tidl_req_if import tidl_pkg::*;;
  logic valid;
  logic ready;
  logic mode;
  q16_t time_now;
  q16_t sample_value;
  q16_t time_step;

  modport source (output valid, mode, time_now, sample_value, time_step, input ready);
  modport sink (input valid, mode, time_now, sample_value, time_step, output ready);
endinterface

interface tidl_rsp_if import tidl_pkg::*;;
  logic       valid;
  logic       ready;
  q16_t       result_value;
  logic [1:0] status;

  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

/* rtl/core/tidl_div.sv */
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module tidl_div import tidl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W:0]   remainder
);

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    rem;
  logic [DCNT_W-1:0] cnt;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial = {rem[DVS_W-1:0], dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? trial - {1'b0, dvs} : trial;
      dvd <= {dvd[DVD_W-2:0], fits};
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

/* rtl/core/timestamped_interpolating_delay_unit.sv */
// Top level: history memories, sequencer and output register of the delay unit.
// With zero delay the sample goes straight to the output register; a record searches the
// history entry by entry, and the first record also pre-fills it (dividing when the step is nonzero).
// An evaluate searches the history entry by entry and may divide to get the interpolation fraction.
// One request at a time; the serial divider and the one-read memory port set the rate.
// Synchronous reset empties the history and clears both registers; memories keep data.
module timestamped_interpolating_delay_unit import tidl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tidl_req_if.sink    req,
  tidl_rsp_if.source  rsp,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PF_DIV = 5'd1;
  localparam logic [4:0] S_PF_MUL = 5'd2;
  localparam logic [4:0] S_PF_WR  = 5'd3;
  localparam logic [4:0] S_DROP0  = 5'd4;
  localparam logic [4:0] S_DROP1  = 5'd5;
  localparam logic [4:0] S_SR_RD  = 5'd6;
  localparam logic [4:0] S_SR_CMP = 5'd7;
  localparam logic [4:0] S_SR_END = 5'd8;
  localparam logic [4:0] S_APPEND = 5'd9;
  localparam logic [4:0] S_EV0    = 5'd10;
  localparam logic [4:0] S_EV1    = 5'd11;
  localparam logic [4:0] S_EV_RD0 = 5'd12;
  localparam logic [4:0] S_EV_RD1 = 5'd13;
  localparam logic [4:0] S_EV_RD2 = 5'd14;
  localparam logic [4:0] S_EV_DIV = 5'd15;
  localparam logic [4:0] S_EV_MUL = 5'd16;
  localparam logic [4:0] S_EV_ADD = 5'd17;
  localparam logic [4:0] S_OUT    = 5'd18;

  q16_t time_mem  [DEPTH];
  q16_t value_mem [DEPTH];

  logic [4:0]       state;
  logic [30:0]      delay_time;
  q16_t             initial_level;
  logic [IDX_W-1:0] oldest;
  logic [CNT_W-1:0] count;

  logic             mode;
  q16_t             now;
  q16_t             val;
  q16_t             step;
  logic signed [33:0] td;
  logic [IDX_W-1:0] k;
  logic [CNT_W-1:0] j;
  logic signed [41:0] pf_prod;
  q16_t             t0, v0, t1, v1;
  logic [16:0]      f;
  logic signed [50:0] ev_prod;
  q16_t             res;
  logic [1:0]       st;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  q16_t             rd_t, rd_v;
  logic             wr_mem;
  logic [IDX_W-1:0] wr_addr;
  q16_t             wr_t, wr_v;

  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic [DVS_W:0]   div_r;

  logic [32:0]      mag;
  logic signed [42:0] pf_diff;
  q16_t             pf_time;
  logic signed [34:0] ev_sum;
  logic [CNT_W-1:0] k_next1;
  logic [33:0]      span;

  assign req.ready = state == S_IDLE;

  assign mag     = step[31] ? 33'(-{step[31], step}) : {1'b0, step};
  assign pf_diff = 43'(now) - 43'(pf_prod);
  assign pf_time = pf_diff > 43'sd2147483647 ? 32'sh7fffffff :
                   pf_diff < -43'sd2147483648 ? 32'sh80000000 : pf_diff[31:0];
  assign ev_sum  = 35'(v0) + 35'(ev_prod >>> 16);
  assign k_next1 = {1'b0, k} + 1'b1;
  assign span    = 34'(td - 34'(t0));

  tidl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = oldest;
    wr_mem    = 1'b0;
    wr_addr   = oldest + count[IDX_W-1:0];
    wr_t      = pf_time;
    wr_v      = initial_level;
    div_start = 1'b0;
    div_dvd   = {19'b0, delay_time};
    div_dvs   = {1'b0, mag};
    case (state)
      S_IDLE: begin
        if (req.valid && delay_time != '0 && !req.mode && count == '0 &&
            req.time_step != '0) begin
          div_start = 1'b1;
          div_dvd   = {19'b0, delay_time};
          div_dvs   = req.time_step[31] ? 34'(-35'(req.time_step)) : 34'(req.time_step);
        end
      end
      S_PF_WR: wr_mem = 1'b1;
      S_DROP0, S_EV0: rd_en = 1'b1;
      S_SR_RD: begin
        rd_en   = 1'b1;
        rd_addr = oldest + k_next1[IDX_W-1:0];
      end
      S_EV_RD0: begin
        rd_en   = 1'b1;
        rd_addr = oldest + k;
      end
      S_EV_RD1: begin
        rd_en   = 1'b1;
        rd_addr = oldest + k_next1[IDX_W-1:0];
      end
      S_EV_RD2: begin
        if (rd_t > t0) begin
          div_start = 1'b1;
          div_dvd   = {span, 16'b0};
          div_dvs   = 34'(35'(rd_t) - 35'(t0));
        end
      end
      S_APPEND: begin
        wr_mem  = 1'b1;
        wr_addr = count[CNT_W-1] ? oldest : oldest + count[IDX_W-1:0];
        wr_t    = now;
        wr_v    = val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_mem) begin
      time_mem[wr_addr]  <= wr_t;
      value_mem[wr_addr] <= wr_v;
    end
    if (rd_en) begin
      rd_t <= time_mem[rd_addr];
      rd_v <= value_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_time    <= '0;
      initial_level <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_DELAY: delay_time    <= wr_data[30:0];
        REG_INIT:  initial_level <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!rsp.valid || rsp.ready)) rsp.valid <= 1'b1;
      else if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode <= req.mode;
            now  <= req.time_now;
            val  <= req.sample_value;
            step <= req.time_step;
            td   <= 34'(req.time_now) - 34'(delay_time);
            res  <= req.sample_value;
            st   <= ST_OK;
            if (delay_time == '0) state <= S_OUT;
            else if (req.mode) state <= S_EV0;
            else if (count != '0) state <= S_DROP0;
            else if (req.time_step == '0) begin
              j     <= CNT_W'(DEPTH);
              state <= S_PF_MUL;
            end else state <= S_PF_DIV;
          end
        end
        S_PF_DIV: begin
          if (div_done) begin
            if (div_q >= DVD_W'(DEPTH)) j <= CNT_W'(DEPTH);
            else j <= div_q[CNT_W-1:0] + CNT_W'(div_r != '0);
            state <= S_PF_MUL;
          end
        end
        S_PF_MUL: begin
          pf_prod <= step * $signed({1'b0, j});
          state   <= S_PF_WR;
        end
        S_PF_WR: begin
          count <= count + 1'b1;
          j     <= j - 1'b1;
          state <= j == CNT_W'(1) ? S_DROP0 : S_PF_MUL;
        end
        S_DROP0: state <= S_DROP1;
        S_DROP1: begin
          k <= '0;
          state <= 34'(rd_t) >= td ? S_APPEND : S_SR_RD;
        end
        S_SR_RD: state <= k_next1 < count ? S_SR_CMP : S_SR_END;
        S_SR_CMP: begin
          if (34'(rd_t) < td) begin
            k     <= k_next1[IDX_W-1:0];
            state <= S_SR_RD;
          end else state <= S_SR_END;
        end
        S_SR_END: begin
          if (mode) state <= S_EV_RD0;
          else begin
            oldest <= oldest + k;
            count  <= count - {1'b0, k};
            state  <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (count[CNT_W-1]) begin
            oldest <= oldest + 1'b1;
            st     <= ST_DROP;
          end else count <= count + 1'b1;
          state <= S_OUT;
        end
        S_EV0: begin
          if (count == '0) begin
            res   <= '0;
            st    <= ST_YOUNG;
            state <= S_OUT;
          end else state <= S_EV1;
        end
        S_EV1: begin
          k <= '0;
          if (34'(rd_t) > td) begin
            res   <= '0;
            st    <= ST_YOUNG;
            state <= S_OUT;
          end else state <= S_SR_RD;
        end
        S_EV_RD0: state <= S_EV_RD1;
        S_EV_RD1: begin
          t0  <= rd_t;
          v0  <= rd_v;
          res <= rd_v;
          if (k_next1 >= count) begin
            st    <= 34'(rd_t) != td ? ST_EARLY : ST_OK;
            state <= S_OUT;
          end else if (34'(rd_t) == td) state <= S_OUT;
          else state <= S_EV_RD2;
        end
        S_EV_RD2: begin
          t1 <= rd_t;
          v1 <= rd_v;
          state <= rd_t > t0 ? S_EV_DIV : S_OUT;
        end
        S_EV_DIV: begin
          if (div_done) begin
            f     <= div_q > DVD_W'(65536) ? 17'd65536 : div_q[16:0];
            state <= S_EV_MUL;
          end
        end
        S_EV_MUL: begin
          ev_prod <= $signed({1'b0, f}) * (33'(v1) - 33'(v0));
          state   <= S_EV_ADD;
        end
        S_EV_ADD: begin
          res <= ev_sum > 35'sd2147483647 ? 32'sh7fffffff :
                 ev_sum < -35'sd2147483648 ? 32'sh80000000 : ev_sum[31:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.result_value <= res;
            rsp.status       <= st;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("history count above depth");
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!rsp.valid || rsp.ready)) |=> rsp.valid && state == S_IDLE)
    else $error("result not loaded");
  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    !(wr_mem && rd_en)) else $error("memory read and write overlap");
`endif

endmodule
